// ===== rtl/ptts_pkg.sv =====
// Shared types and codes for the periodic task tick scheduler.
// No dependencies; ptts_dp, ptts_ctrl and the top level import this package.
`timescale 1ns / 1ps

package ptts_pkg;

  // Command selector codes.
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_CREATE  = 3'd1;
  localparam logic [2:0] FUNC_DELETE  = 3'd2;
  localparam logic [2:0] FUNC_SUSPEND = 3'd3;
  localparam logic [2:0] FUNC_RESUME  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OCCUPIED = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // Per-slot run states.
  localparam logic [1:0] RS_DORMANT   = 2'd0;
  localparam logic [1:0] RS_READY     = 2'd1;
  localparam logic [1:0] RS_RUNNING   = 2'd2;
  localparam logic [1:0] RS_SUSPENDED = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [15:0] period;
    logic [15:0] first_delay;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] fire_mask;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;
    logic exec;
    logic walk_init;
    logic walk_step;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic walk_done;
  } stat_t;

endpackage

// ===== rtl/ptts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ptts_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptts_dp.sv =====
// Datapath of the tick scheduler: input and output registers, slot flags,
// the period/countdown RAM and the tick walk. Depends on ptts_pkg and ptts_ram.
`timescale 1ns / 1ps

module ptts_dp #(
  parameter int NUM_TASKS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ptts_pkg::in_t  in_data,
  input  ptts_pkg::ctl_t ctl,
  output ptts_pkg::stat_t stat,
  output ptts_pkg::out_t out_data
);

  import ptts_pkg::*;

  localparam int IW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNTW = $clog2(NUM_TASKS + 1);
  localparam int RW   = 2 * COUNT_WIDTH;

  in_t                    in_r;
  out_t                   out_r;
  logic [1:0]             status_r;
  logic [7:0]             mask_r;
  logic [CNTW-1:0]        walk_cnt_r;
  logic                   proc_vld_r;
  logic [IW-1:0]          proc_idx_r;
  logic [NUM_TASKS-1:0]   used_r;
  logic [1:0]             rs_r [NUM_TASKS];

  logic                   in_rng;
  logic [IW-1:0]          sidx;
  logic [IW-1:0]          acc_idx;
  logic                   acc_used;
  logic [1:0]             acc_rs;
  logic                   rd_en;
  logic [RW-1:0]          rd_data;
  logic [COUNT_WIDTH-1:0] rd_per;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic                   tk_act;
  logic                   tk_fire;

  logic [1:0]             ex_status;
  logic                   ex_we;
  logic                   ex_set_used;
  logic                   ex_clr_used;
  logic                   ex_rs_we;
  logic [1:0]             ex_rs_val;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [RW-1:0]          ram_wdata;

  assign in_rng = (32'(in_r.slot) < 32'(NUM_TASKS));
  assign sidx   = IW'(in_r.slot);

  // Commands and the tick walk never overlap, so the flags share one read port.
  assign acc_idx  = proc_vld_r ? proc_idx_r : sidx;
  assign acc_used = used_r[acc_idx];
  assign acc_rs   = rs_r[acc_idx];

  assign rd_en = ctl.walk_step && (walk_cnt_r < CNTW'(NUM_TASKS));

  assign rd_per = rd_data[RW-1:COUNT_WIDTH];
  assign rd_cnt = rd_data[COUNT_WIDTH-1:0];

  assign tk_act  = proc_vld_r && acc_used && ((acc_rs == RS_READY) || (acc_rs == RS_RUNNING));
  assign tk_fire = tk_act && (rd_cnt == '0);

  always_comb begin
    ex_status   = STAT_OK;
    ex_we       = 1'b0;
    ex_set_used = 1'b0;
    ex_clr_used = 1'b0;
    ex_rs_we    = 1'b0;
    ex_rs_val   = RS_DORMANT;
    case (in_r.func)
      FUNC_CREATE: begin
        if (!in_rng) begin
          ex_status = STAT_RANGE;
        end else if (acc_used) begin
          ex_status = STAT_OCCUPIED;
        end else begin
          ex_we       = 1'b1;
          ex_set_used = 1'b1;
          ex_rs_we    = 1'b1;
          ex_rs_val   = RS_READY;
        end
      end
      FUNC_DELETE, FUNC_SUSPEND, FUNC_RESUME: begin
        if (!in_rng) begin
          ex_status = STAT_RANGE;
        end else if (!acc_used) begin
          ex_status = STAT_EMPTY;
        end else begin
          ex_rs_we = 1'b1;
          if (in_r.func == FUNC_DELETE) begin
            ex_clr_used = 1'b1;
            ex_rs_val   = RS_DORMANT;
          end else if (in_r.func == FUNC_SUSPEND) begin
            ex_rs_val = RS_SUSPENDED;
          end else begin
            ex_rs_val = RS_READY;
          end
        end
      end
      default: begin
        ex_status = STAT_OK;
      end
    endcase
  end

  always_comb begin
    if (proc_vld_r) begin
      ram_we    = tk_act;
      ram_waddr = proc_idx_r;
      ram_wdata = tk_fire ? {rd_per, rd_per} : {rd_per, rd_cnt - COUNT_WIDTH'(1)};
    end else begin
      ram_we    = ctl.exec && ex_we;
      ram_waddr = sidx;
      ram_wdata = {COUNT_WIDTH'(in_r.period), COUNT_WIDTH'(in_r.first_delay)};
    end
  end

  ptts_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_TASKS),
    .ADDR_W(IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(walk_cnt_r[IW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      proc_vld_r <= 1'b0;
      walk_cnt_r <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        rs_r[i] <= RS_DORMANT;
      end
    end else begin
      proc_vld_r <= rd_en;
      if (ctl.walk_init) begin
        walk_cnt_r <= '0;
      end else if (rd_en) begin
        walk_cnt_r <= walk_cnt_r + CNTW'(1);
      end
      if (ctl.exec) begin
        if (ex_set_used) begin
          used_r[sidx] <= 1'b1;
        end
        if (ex_clr_used) begin
          used_r[sidx] <= 1'b0;
        end
        if (ex_rs_we) begin
          rs_r[sidx] <= ex_rs_val;
        end
      end
      if (tk_fire) begin
        rs_r[proc_idx_r] <= RS_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= walk_cnt_r[IW-1:0];
    if (ctl.cap_in) begin
      in_r     <= in_data;
      status_r <= STAT_OK;
      mask_r   <= '0;
    end else begin
      if (ctl.exec) begin
        status_r <= ex_status;
      end
      // Slots above bit 7 shift out and never show in the mask.
      if (tk_fire) begin
        mask_r <= mask_r | (8'(1) << proc_idx_r);
      end
    end
    if (ctl.out_load) begin
      out_r.status    <= status_r;
      out_r.fire_mask <= mask_r;
    end
  end

  assign stat.is_tick   = (in_r.func == FUNC_TICK);
  assign stat.walk_done = (walk_cnt_r == CNTW'(NUM_TASKS)) && !proc_vld_r;
  assign out_data       = out_r;

  a_rd_then_proc: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> proc_vld_r)
    else $error("read issued without a processing cycle after it");

  a_no_cmd_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    proc_vld_r |-> !ctl.exec && !ctl.cap_in)
    else $error("command executed while the tick walk is active");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    walk_cnt_r <= CNTW'(NUM_TASKS))
    else $error("tick walk counter ran past the last slot");

endmodule

// ===== rtl/ptts_ctrl.sv =====
// Controller of the tick scheduler: sequences capture, command execution,
// the slot walk and the output handshake. Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ptts_pkg::stat_t stat,
  output ptts_pkg::ctl_t  ctl
);

  import ptts_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap_in = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_tick) begin
          ctl.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_WALK: begin
        ctl.walk_step = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> out_free)
    else $error("output word overwritten before it was taken");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted word did not start execution");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// Top level of the periodic task tick scheduler.
// Depends on ptts_pkg, ptts_ctrl, ptts_dp and ptts_ram.
//
//   channel | direction | ports                          | word
//   --------+-----------+--------------------------------+----------------------------
//   in      | input     | in_valid, in_ready, in_data    | func, slot, period, delay
//   out     | output    | out_valid, out_ready, out_data | status, fire_mask
//
// A create, delete, suspend or resume passes from acceptance through the execute
// and final states to the result register. A tick walks the task table one
// slot per cycle through the single read port of the period/countdown RAM.
// Reset (rst_n, synchronous) frees every slot; the RAM needs no clearing.
// A new word is accepted while the previous result still waits in the output
// register; a stalled output holds only the final load of the next result.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_core #(
  parameter int NUM_TASKS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ptts_pkg::out_t out_data
);

  import ptts_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ptts_dp #(
    .NUM_TASKS  (NUM_TASKS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .ctl     (ctl),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule
